### rtl/wbss_pkg.sv
`default_nettype none
package wbss_pkg;

	// Design limits and fixed field widths.
	localparam int unsigned MAX_SIGNATURE_DEF = 16;
	localparam int unsigned SIG_BYTES         = 16;
	localparam int unsigned CNT_W             = 32;
	localparam int unsigned LEN_W             = 5;
	localparam int unsigned CFG_IDX_W         = 2;
	localparam int unsigned CFG_DATA_W        = 64;
	localparam int unsigned WILD_W            = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SIG_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIG_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WILDCARD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 2'd3;

	// Active signature setup as seen by the scan logic.
	typedef struct packed {
		logic [SIG_BYTES*8-1:0] sig;
		logic [WILD_W-1:0]      wild;
		logic [LEN_W-1:0]       len;
	} cfg_t;

	// Result produced by the scan logic for the item in the input stage.
	typedef struct packed {
		logic             hit;
		logic             found;
		logic [CNT_W-1:0] offset;
	} res_t;

endpackage
`default_nettype wire

### rtl/wbss_cfg.sv
`default_nettype none
module wbss_cfg #(
	parameter int unsigned MAX_SIGNATURE = wbss_pkg::MAX_SIGNATURE_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_write,
	input  wire logic [wbss_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [wbss_pkg::CFG_DATA_W-1:0]  cfg_data,
	output wbss_pkg::cfg_t                        cfg
);
	import wbss_pkg::*;

	logic [CFG_DATA_W-1:0] sig_low_q;
	logic [CFG_DATA_W-1:0] sig_high_q;
	logic [WILD_W-1:0]     wild_q;
	logic [LEN_W-1:0]      len_q;

	// Register writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_low_q  <= '0;
			sig_high_q <= '0;
			wild_q     <= '0;
			len_q      <= LEN_W'(1);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SIG_LOW:  sig_low_q  <= cfg_data;
				REG_SIG_HIGH: sig_high_q <= cfg_data;
				REG_WILDCARD: wild_q     <= cfg_data[WILD_W-1:0];
				REG_LENGTH:   len_q      <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the length into the supported range of one to MAX_SIGNATURE.
	always_comb begin
		cfg.sig  = {sig_high_q, sig_low_q};
		cfg.wild = wild_q;
		if (len_q == '0) begin
			cfg.len = LEN_W'(1);
		end else if (len_q > LEN_W'(MAX_SIGNATURE)) begin
			cfg.len = LEN_W'(MAX_SIGNATURE);
		end else begin
			cfg.len = len_q;
		end
	end

endmodule
`default_nettype wire

### rtl/wbss_scan.sv
`default_nettype none
module wbss_scan #(
	parameter int unsigned MAX_SIGNATURE = wbss_pkg::MAX_SIGNATURE_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire wbss_pkg::cfg_t cfg,
	input  wire logic           step,
	input  wire logic [7:0]     byte_in,
	input  wire logic           last_in,
	output wbss_pkg::res_t      res
);
	import wbss_pkg::*;

	localparam int unsigned HIST_D = (MAX_SIGNATURE > 1) ? MAX_SIGNATURE - 1 : 1;
	localparam int unsigned IDX_W  = (MAX_SIGNATURE > 1) ? $clog2(MAX_SIGNATURE) : 1;

	logic [7:0]       hist_q [HIST_D];
	logic [CNT_W-1:0] count_q;
	logic             reported_q;

	logic [7:0]       win [MAX_SIGNATURE];
	logic [CNT_W-1:0] count_inc;
	logic             window_ok;
	logic             match;

	// Window of the newest bytes: entry 0 is the current byte.
	always_comb begin
		win[0] = byte_in;
		for (int j = 1; j < MAX_SIGNATURE; j++) begin
			win[j] = hist_q[j-1];
		end
	end

	// Parallel compare of each unmasked signature byte below the length against its window position.
	always_comb begin
		logic [LEN_W-1:0] back;
		window_ok = 1'b1;
		for (int k = 0; k < MAX_SIGNATURE; k++) begin
			back = cfg.len - LEN_W'(k) - LEN_W'(1);
			if (LEN_W'(k) < cfg.len && !cfg.wild[k]
					&& win[back[IDX_W-1:0]] != cfg.sig[8*k +: 8]) begin
				window_ok = 1'b0;
			end
		end
	end

	// Saturating byte count and the result for this byte.
	always_comb begin
		count_inc  = (count_q == '1) ? count_q : count_q + CNT_W'(1);
		match      = !reported_q && count_inc >= CNT_W'(cfg.len) && window_ok;
		res.hit    = match || (!reported_q && last_in);
		res.found  = match;
		res.offset = match ? count_inc - CNT_W'(cfg.len) : '0;
	end

	// Scan state: cleared after the final byte of an image.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			reported_q <= 1'b0;
			for (int j = 0; j < HIST_D; j++) begin
				hist_q[j] <= '0;
			end
		end else if (step) begin
			if (last_in) begin
				count_q    <= '0;
				reported_q <= 1'b0;
				for (int j = 0; j < HIST_D; j++) begin
					hist_q[j] <= '0;
				end
			end else begin
				count_q    <= count_inc;
				reported_q <= reported_q | match;
				hist_q[0]  <= byte_in;
				for (int j = 1; j < HIST_D; j++) begin
					hist_q[j] <= hist_q[j-1];
				end
			end
		end
	end

`ifndef SYNTHESIS
	// The final byte leaves the scan state clear.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_in |=> count_q == '0 && !reported_q)
		else $error("scan state not cleared after final byte");

	// A match is never reported twice within one image.
	a_single_report: assert property (@(posedge clk) disable iff (!arst_n)
		res.hit |-> !reported_q)
		else $error("second result within one image");

	// A consumed match marks the image as reported unless it was the final byte.
	a_mark_reported: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.found && !last_in |=> reported_q)
		else $error("match not recorded");
`endif

endmodule
`default_nettype wire

### rtl/wildcard_byte_signature_search.sv
`default_nettype none
// Wildcard byte signature search.
// Input channel (in_valid/in_ready): one image byte per transfer, with is_last
// marking the final byte of an image. Output channel (out_valid/out_ready):
// at most one result per image, either found with the offset of the first
// match start, or not found (offset zero) when the final byte arrives first.
// The configuration port takes a write on any cycle with cfg_write high:
// index 0 and 1 hold signature bytes 0-7 and 8-15, index 2 the wildcard mask,
// index 3 the signature length. Write it only while no image is in flight.
// A transferred byte is registered in the input stage; its result is captured
// in the output register when the input stage advances.
// Throughput: one byte per cycle unless a held result stalls the input stage.
// The compare of all signature bytes with input stage and history is combinational.
// Reset clears the pipeline, the history, the byte count and the registers
// (length reads as one). When the receiver stalls, the held result blocks
// the input stage only if that stage also has a result to deliver; bytes
// that produce no result keep flowing.
module wildcard_byte_signature_search #(
	parameter int unsigned MAX_SIGNATURE = wbss_pkg::MAX_SIGNATURE_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write,
	input  wire logic [wbss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [wbss_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [7:0]                      image_byte,
	input  wire logic                            is_last,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 found,
	output logic [wbss_pkg::CNT_W-1:0]           match_offset
);
	import wbss_pkg::*;

	cfg_t             cfg;
	res_t             res;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic             s1_adv;
	logic             out_free;
	logic             out_valid_q;
	logic             found_q;
	logic [CNT_W-1:0] offset_q;

	wbss_cfg #(
		.MAX_SIGNATURE(MAX_SIGNATURE)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	wbss_scan #(
		.MAX_SIGNATURE(MAX_SIGNATURE)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (s1_adv),
		.byte_in(byte_s1),
		.last_in(last_s1),
		.res    (res)
	);

	// The input stage moves on unless it has a result and the output is full.
	assign out_free = !out_valid_q || out_ready;
	assign s1_adv   = valid_s1 && (!res.hit || out_free);
	assign in_ready = !valid_s1 || s1_adv;

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= image_byte;
			last_s1 <= is_last;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && res.hit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && res.hit) begin
			found_q  <= res.found;
			offset_q <= res.offset;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign match_offset = offset_q;

`ifndef SYNTHESIS
	// A result leaving the input stage is always captured in the output register.
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && res.hit |=> out_valid_q)
		else $error("result lost between stages");

	// A not-found result carries a zero offset.
	a_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> offset_q == '0)
		else $error("nonzero offset on not-found result");

	// A stalled result is never overwritten by the input stage.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !(s1_adv && res.hit))
		else $error("held result overwritten");
`endif

endmodule
`default_nettype wire
